>>> src/imu_prp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imu_prp_pkg
// Shared types, record id table and lookup for the IMU packet record parser.
// ----------------------------------------------------------------------------
package imu_prp_pkg;

    localparam int unsigned NumKnown = 7;

    // default accepted message id after reset
    localparam logic [7:0] DefaultMsgId = 8'h36;

    // dense item codes
    localparam logic [2:0] ItemTimestamp  = 3'd0;
    localparam logic [2:0] ItemQuaternion = 3'd1;
    localparam logic [2:0] ItemDeltaV     = 3'd2;
    localparam logic [2:0] ItemAccel      = 3'd3;
    localparam logic [2:0] ItemGyro       = 3'd4;
    localparam logic [2:0] ItemDeltaQ     = 3'd5;
    localparam logic [2:0] ItemMagnetic   = 3'd6;

    // record ids, indexed by item code
    localparam logic [15:0] KnownIds [NumKnown] = '{
        16'h1060, 16'h2010, 16'h4010, 16'h4020, 16'h8020, 16'h8030, 16'hC020
    };

    // words per record, indexed by item code
    localparam logic [2:0] KnownWords [NumKnown] = '{
        3'd1, 3'd4, 3'd3, 3'd3, 3'd3, 3'd4, 3'd3
    };

    typedef struct packed {
        logic       hit;
        logic [2:0] item;
        logic [2:0] words;
    } lookup_t;

    typedef struct packed {
        logic [2:0]  item_code;
        logic [1:0]  element_index;
        logic [31:0] word_value;
    } result_t;

    // map a record id to its item code and word count
    function automatic lookup_t lookup_record(input logic [15:0] id);
        lookup_t res;
        res = '0;
        for (int unsigned k = 0; k < NumKnown; k++)
        begin
            if (!res.hit && KnownIds[k] == id)
            begin
                res.hit   = 1'b1;
                res.item  = 3'(k);
                res.words = KnownWords[k];
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

>>> src/imu_prp_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imu_prp_core
// Record parse state; consumes one byte per step and flags a finished word.
// ----------------------------------------------------------------------------
module imu_prp_core
    import imu_prp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] data_byte,
    input  wire logic [7:0] msg_id,
    input  wire logic       last_byte,
    input  wire logic [7:0] accepted_id,
    output logic            emit,
    output result_t         result
);

    typedef enum logic [2:0] {
        PH_ID_HI = 3'd0,
        PH_ID_LO = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_SKIP  = 3'd4
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] record_id_reg, record_id_next;
    logic [7:0]  skip_count_reg, skip_count_next;
    logic [2:0]  current_item_reg, current_item_next;
    logic [1:0]  element_count_reg, element_count_next;
    logic [2:0]  elements_left_reg, elements_left_next;
    logic [1:0]  byte_in_word_reg, byte_in_word_next;
    logic [23:0] word_shift_reg, word_shift_next;
    lookup_t     lookup;
    logic [2:0]  left_dec;
    logic [7:0]  skip_dec;

    assign lookup   = lookup_record(record_id_reg);
    assign left_dec = elements_left_reg - 3'd1;
    assign skip_dec = skip_count_reg - 8'd1;

    // finished word goes out with the current record fields
    assign result.item_code     = current_item_reg;
    assign result.element_index = element_count_reg;
    assign result.word_value    = {word_shift_reg, data_byte};

    // next state for one byte
    always_comb
    begin
        phase_next         = phase_reg;
        record_id_next     = record_id_reg;
        skip_count_next    = skip_count_reg;
        current_item_next  = current_item_reg;
        element_count_next = element_count_reg;
        elements_left_next = elements_left_reg;
        byte_in_word_next  = byte_in_word_reg;
        word_shift_next    = word_shift_reg;
        emit               = 1'b0;

        if (step && msg_id == accepted_id)
        begin
            case (phase_reg)
                PH_ID_LO:
                begin
                    record_id_next = {record_id_reg[15:8], data_byte};
                    phase_next     = PH_LEN;
                end
                PH_LEN:
                begin
                    if (lookup.hit)
                    begin
                        current_item_next  = lookup.item;
                        elements_left_next = lookup.words;
                        element_count_next = 2'd0;
                        byte_in_word_next  = 2'd0;
                        word_shift_next    = '0;
                        phase_next         = PH_DATA;
                    end
                    else
                    begin
                        skip_count_next = data_byte;
                        phase_next      = (data_byte == 8'd0) ? PH_ID_HI : PH_SKIP;
                    end
                end
                PH_DATA:
                begin
                    if (byte_in_word_reg != 2'd3)
                    begin
                        word_shift_next   = {word_shift_reg[15:0], data_byte};
                        byte_in_word_next = byte_in_word_reg + 2'd1;
                    end
                    else
                    begin
                        emit               = 1'b1;
                        element_count_next = element_count_reg + 2'd1;
                        elements_left_next = left_dec;
                        byte_in_word_next  = 2'd0;
                        word_shift_next    = '0;
                        if (left_dec == 3'd0)
                        begin
                            phase_next = PH_ID_HI;
                        end
                    end
                end
                PH_SKIP:
                begin
                    skip_count_next = skip_dec;
                    if (skip_dec == 8'd0)
                    begin
                        phase_next = PH_ID_HI;
                    end
                end
                default:
                begin
                    record_id_next = {data_byte, 8'd0};
                    phase_next     = PH_ID_LO;
                end
            endcase

            // end of message drops any partial record
            if (last_byte)
            begin
                phase_next         = PH_ID_HI;
                record_id_next     = '0;
                skip_count_next    = '0;
                current_item_next  = '0;
                element_count_next = '0;
                elements_left_next = '0;
                byte_in_word_next  = '0;
                word_shift_next    = '0;
            end
        end
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_ID_HI;
            record_id_reg     <= '0;
            skip_count_reg    <= '0;
            current_item_reg  <= '0;
            element_count_reg <= '0;
            elements_left_reg <= '0;
            byte_in_word_reg  <= '0;
            word_shift_reg    <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            record_id_reg     <= record_id_next;
            skip_count_reg    <= skip_count_next;
            current_item_reg  <= current_item_next;
            element_count_reg <= element_count_next;
            elements_left_reg <= elements_left_next;
            byte_in_word_reg  <= byte_in_word_next;
            word_shift_reg    <= word_shift_next;
        end
    end

endmodule
`default_nettype wire

>>> src/imu_packet_record_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imu_packet_record_parser
// Parses record streams from sensor message payloads into tagged 32-bit words.
// ----------------------------------------------------------------------------
//  channel | dir | content
//  s_*     | in  | tdata: data_byte; tuser: msg_id; tlast: last_byte
//  m_*     | out | tdata: element_index, word_value; tuser: item_code
//  cfg_*   | in  | cfg_data: accepted message id, ready always high
//
//  One byte per cycle while the result is not stalled; after the transfer
//  of its fourth byte a word passes the input and then the result register.
//  The parse state updates as a byte leaves the input register, so the
//  per-byte state loop sets the rate. Reset clears the parse state and valid
//  flags and loads the accepted id 0x36. A stalled result holds both
//  stages; s_tready drops only when the input and result registers are full.
// ----------------------------------------------------------------------------
module imu_packet_record_parser
    import imu_prp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [7:0]  s_tuser,   // [7:0] msg_id
    input  wire logic        s_tlast,   // last_byte
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [1:0] element_index, [33:2] word_value
    output logic [2:0]       m_tuser,   // [2:0] item_code
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data
);

    logic [7:0] cfg_id_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic [7:0] in_msg_id_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    result_t    out_result_reg;
    logic       advance;
    logic       emit;
    result_t    result;

    assign cfg_ready = 1'b1;

    // input register drains whenever the result slot is free
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_id_reg <= DefaultMsgId;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cfg_id_reg <= cfg_data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg   <= s_tdata;
            in_msg_id_reg <= s_tuser;
            in_last_reg   <= s_tlast;
        end
    end

    // parse state and word assembly
    imu_prp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (in_valid_reg && advance),
        .data_byte   (in_byte_reg),
        .msg_id      (in_msg_id_reg),
        .last_byte   (in_last_reg),
        .accepted_id (cfg_id_reg),
        .emit        (emit),
        .result      (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg && emit)
        begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.item_code;
    assign m_tdata  = {6'd0, out_result_reg.word_value, out_result_reg.element_index};

    // a held byte stays put while the result slot is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg)
            && $stable(in_msg_id_reg) && $stable(in_last_reg))
        else $error("input register changed while stalled");

    // back-pressure only with both stages full
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled with a free stage");

    // only defined item codes leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= ItemMagnetic)
        else $error("undefined item code on result");

    // a word is produced only from a byte of the accepted message
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && advance && emit |-> in_msg_id_reg == cfg_id_reg)
        else $error("word emitted for a foreign message");

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the IMU packet record parser. Payload bytes are
// queued as whole messages with random record content, mixed with foreign
// message bytes, truncated messages and noise, and sent through a stream
// driver with random idle bursts. Every accepted byte runs through an
// in-bench parser that predicts the tagged words. A monitor compares each
// result transfer with the oldest predicted word. The accepted message id
// is changed between phases, including once in the middle of a record.
// ----------------------------------------------------------------------------
module testbench;
    import imu_prp_pkg::*;

    // record ids of the known records
    localparam logic [15:0] RecTimestamp  = 16'h1060;
    localparam logic [15:0] RecQuaternion = 16'h2010;
    localparam logic [15:0] RecDeltaV     = 16'h4010;
    localparam logic [15:0] RecAccel      = 16'h4020;
    localparam logic [15:0] RecGyro       = 16'h8020;
    localparam logic [15:0] RecDeltaQ     = 16'h8030;
    localparam logic [15:0] RecMagnetic   = 16'hC020;

    localparam logic [15:0] RecordIds [7] = '{
        RecTimestamp, RecQuaternion, RecDeltaV, RecAccel, RecGyro, RecDeltaQ, RecMagnetic
    };

    localparam int CycleLimit   = 400000;
    localparam int DrainCycles  = 8;
    localparam int HoldCycles   = 250;
    localparam int PhaseBytes   = 280;
    localparam int MaxReported  = 10;

    typedef enum logic [2:0] {
        PhIdHi = 3'd0,
        PhIdLo = 3'd1,
        PhLen  = 3'd2,
        PhData = 3'd3,
        PhSkip = 3'd4
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] msg_id;
        logic       is_last;
    } payload_byte_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] item;
        logic [2:0] words;
    } record_info_t;

    // dut ports
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic [7:0]  s_tuser   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;

    // stimulus and checking state
    payload_byte_t byte_queue [$];
    result_t       expected_words [$];
    int            queued_bytes   = 0;
    int            mismatch_count = 0;
    int            cycle_count    = 0;
    int            src_gap        = 0;
    int            sink_gap       = 0;
    int            hold_left      = 0;
    logic          hold_armed     = 1'b0;
    logic          hold_done      = 1'b0;
    logic          src_idle_on    = 1'b1;
    logic          sink_idle_on   = 1'b1;

    // parser state of the prediction
    logic [7:0]    accepted_id = DefaultMsgId;
    parse_phase_t  parse_state;
    logic [15:0]   rec_id;
    logic [7:0]    skip_left;
    logic [2:0]    cur_item;
    logic [1:0]    elem_idx;
    logic [2:0]    words_left;
    logic [1:0]    byte_pos;
    logic [23:0]   word_bytes;

    imu_packet_record_parser u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // item code and word count of a record id
    function automatic record_info_t record_info(input logic [15:0] id);
        record_info_t info;
        info.hit = 1'b1;
        case (id)
            RecTimestamp:
            begin
                info.item  = ItemTimestamp;
                info.words = 3'd1;
            end
            RecQuaternion:
            begin
                info.item  = ItemQuaternion;
                info.words = 3'd4;
            end
            RecDeltaV:
            begin
                info.item  = ItemDeltaV;
                info.words = 3'd3;
            end
            RecAccel:
            begin
                info.item  = ItemAccel;
                info.words = 3'd3;
            end
            RecGyro:
            begin
                info.item  = ItemGyro;
                info.words = 3'd3;
            end
            RecDeltaQ:
            begin
                info.item  = ItemDeltaQ;
                info.words = 3'd4;
            end
            RecMagnetic:
            begin
                info.item  = ItemMagnetic;
                info.words = 3'd3;
            end
            default:
            begin
                info.hit   = 1'b0;
                info.item  = '0;
                info.words = '0;
            end
        endcase
        return info;
    endfunction

    function automatic void clear_parse();
        parse_state = PhIdHi;
        rec_id      = '0;
        skip_left   = '0;
        cur_item    = '0;
        elem_idx    = '0;
        words_left  = '0;
        byte_pos    = '0;
        word_bytes  = '0;
    endfunction

    // advance the predicted parser by one accepted byte, queue a finished word
    function automatic void parse_byte(input logic [7:0] b, input logic [7:0] mid,
                                       input logic is_last);
        record_info_t info;
        result_t      word;
        if (mid != accepted_id)
            return;
        case (parse_state)
            PhIdLo:
            begin
                rec_id[7:0] = b;
                parse_state = PhLen;
            end
            PhLen:
            begin
                info = record_info(rec_id);
                if (info.hit)
                begin
                    cur_item    = info.item;
                    words_left  = info.words;
                    elem_idx    = '0;
                    byte_pos    = '0;
                    word_bytes  = '0;
                    parse_state = PhData;
                end
                else
                begin
                    skip_left   = b;
                    parse_state = (b == 8'd0) ? PhIdHi : PhSkip;
                end
            end
            PhData:
            begin
                if (byte_pos != 2'd3)
                begin
                    word_bytes = {word_bytes[15:0], b};
                    byte_pos   = byte_pos + 2'd1;
                end
                else
                begin
                    word.item_code     = cur_item;
                    word.element_index = elem_idx;
                    word.word_value    = {word_bytes, b};
                    expected_words.push_back(word);
                    elem_idx   = elem_idx + 2'd1;
                    words_left = words_left - 3'd1;
                    byte_pos   = '0;
                    word_bytes = '0;
                    if (words_left == 3'd0)
                        parse_state = PhIdHi;
                end
            end
            PhSkip:
            begin
                skip_left = skip_left - 8'd1;
                if (skip_left == 8'd0)
                    parse_state = PhIdHi;
            end
            default:
            begin
                rec_id      = {b, 8'h00};
                parse_state = PhIdLo;
            end
        endcase
        // end of message drops any partial record
        if (is_last)
            clear_parse();
    endfunction

    // input driver: present queued bytes, random idle bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            s_tlast  <= 1'b0;
            src_gap  <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
            begin
                parse_byte(s_tdata, s_tuser, s_tlast);
                void'(byte_queue.pop_front());
            end
            if (src_gap != 0)
            begin
                src_gap  <= src_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (byte_queue.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= byte_queue[0].data;
                s_tuser  <= byte_queue[0].msg_id;
                s_tlast  <= byte_queue[0].is_last;
                if (src_idle_on && $urandom_range(0, 7) == 0)
                    src_gap <= $urandom_range(1, 10);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // compare one result transfer with the oldest predicted word
    function automatic void check_word();
        result_t got;
        result_t want;
        got.item_code     = m_tuser;
        got.element_index = m_tdata[1:0];
        got.word_value    = m_tdata[33:2];
        if (expected_words.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MaxReported)
                $display("unexpected word: item %0d index %0d value %08h",
                         got.item_code, got.element_index, got.word_value);
        end
        else
        begin
            want = expected_words.pop_front();
            if (got.item_code !== want.item_code
                || got.element_index !== want.element_index
                || got.word_value !== want.word_value)
            begin
                mismatch_count++;
                if (mismatch_count <= MaxReported)
                    $display("word mismatch (exp/act): item %0d/%0d index %0d/%0d value %08h/%08h",
                             want.item_code, got.item_code, want.element_index,
                             got.element_index, want.word_value, got.word_value);
            end
        end
    endfunction

    // result monitor: check transfers, random backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_gap <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_word();
            if (hold_left != 0)
            begin
                m_tready <= 1'b0;
            end
            else if (sink_gap != 0)
            begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (sink_idle_on && $urandom_range(0, 7) == 0)
                    sink_gap <= $urandom_range(1, 10);
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_armed && !hold_done)
        begin
            hold_left <= HoldCycles;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] data, input logic [7:0] mid,
                             input logic is_last);
        payload_byte_t pb;
        pb.data    = data;
        pb.msg_id  = mid;
        pb.is_last = is_last;
        byte_queue.push_back(pb);
        if (mid == accepted_id)
            queued_bytes++;
    endtask

    function automatic logic [7:0] foreign_mid();
        logic [7:0] mid;
        do
            mid = 8'($urandom);
        while (mid == accepted_id);
        return mid;
    endfunction

    // one message: records with random content, sometimes noise or cut short
    task automatic queue_message(input logic closed, input logic allow_broken);
        logic [7:0]   body [$];
        logic [15:0]  rid;
        logic [7:0]   len;
        record_info_t info;
        int           kind;
        int           cut;
        kind = allow_broken ? $urandom_range(0, 19) : 19;
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 8))
                body.push_back(8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    rid = RecordIds[$urandom_range(0, 6)];
                    len = 8'($urandom);
                end
                else
                begin
                    do
                    begin
                        rid  = 16'($urandom);
                        info = record_info(rid);
                    end
                    while (info.hit);
                    len = ($urandom_range(0, 15) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(0, 5));
                end
                info = record_info(rid);
                body.push_back(rid[15:8]);
                body.push_back(rid[7:0]);
                body.push_back(len);
                if (info.hit)
                    repeat (int'(info.words) * 4)
                        body.push_back(8'($urandom));
                else
                    repeat (int'(len))
                        body.push_back(8'($urandom));
            end
            // broken message: the end may fall inside a record
            if (kind == 1)
            begin
                cut = $urandom_range(1, body.size());
                while (body.size() > cut)
                    void'(body.pop_back());
            end
        end
        foreach (body[i])
        begin
            if ($urandom_range(0, 11) == 0)
                push_byte(8'($urandom), foreign_mid(), 1'($urandom));
            push_byte(body[i], accepted_id, closed && (i == body.size() - 1));
        end
    endtask

    task automatic queue_messages(input int target, input logic allow_broken);
        int start;
        start = queued_bytes;
        while (queued_bytes - start < target)
            queue_message(1'b1, allow_broken);
    endtask

    // block idle: all bytes sent, all words back, pipeline flushed
    task automatic wait_drained();
        while (byte_queue.size() != 0 || expected_words.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_accepted_id(input logic [7:0] id);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= id;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid   <= 1'b0;
        accepted_id = id;
    endtask

    task automatic start_phase(input logic [7:0] id, input logic idle_on);
        wait_drained();
        write_accepted_id(id);
        @(negedge clk);
        src_idle_on  = idle_on;
        sink_idle_on = idle_on;
    endtask

    // stimulus
    initial
    begin
        clear_parse();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, reset id: unknown with zero length, unknown skip,
        // foreign byte flagged last, word completed by the last byte
        push_byte(8'h12, accepted_id, 1'b0);
        push_byte(8'h34, accepted_id, 1'b0);
        push_byte(8'h00, accepted_id, 1'b0);
        push_byte(8'hAB, accepted_id, 1'b0);
        push_byte(8'hCD, accepted_id, 1'b0);
        push_byte(8'h01, accepted_id, 1'b0);
        push_byte(8'h5A, accepted_id, 1'b0);
        push_byte(8'h77, foreign_mid(), 1'b1);
        push_byte(RecTimestamp[15:8], accepted_id, 1'b0);
        push_byte(RecTimestamp[7:0], accepted_id, 1'b0);
        push_byte(8'h00, accepted_id, 1'b0);
        repeat (3) push_byte(8'hFF, accepted_id, 1'b0);
        push_byte(8'hFF, accepted_id, 1'b1);
        // partial quaternion dropped at end of message
        push_byte(RecQuaternion[15:8], accepted_id, 1'b0);
        push_byte(RecQuaternion[7:0], accepted_id, 1'b0);
        push_byte(8'h10, accepted_id, 1'b0);
        push_byte(8'h01, accepted_id, 1'b0);
        push_byte(8'h02, accepted_id, 1'b1);
        // gyro record left open across the id change
        push_byte(RecGyro[15:8], accepted_id, 1'b0);
        push_byte(RecGyro[7:0], accepted_id, 1'b0);
        push_byte(8'h07, accepted_id, 1'b0);
        push_byte(8'h11, accepted_id, 1'b0);
        push_byte(8'h22, accepted_id, 1'b0);

        // lowest id, finish the open record under it
        start_phase(8'h00, 1'b1);
        push_byte(8'h33, accepted_id, 1'b0);
        push_byte(8'h44, accepted_id, 1'b0);
        repeat (7) push_byte(8'($urandom), accepted_id, 1'b0);
        push_byte(8'($urandom), accepted_id, 1'b1);
        queue_messages(PhaseBytes, 1'b1);

        // highest id
        start_phase(8'hFF, 1'b1);
        queue_messages(PhaseBytes, 1'b1);

        // sender runs flat out while the receiver holds off
        start_phase(8'($urandom), 1'b0);
        hold_armed = 1'b1;
        queue_messages(PhaseBytes, 1'b0);

        start_phase(8'($urandom), 1'b1);
        queue_messages(PhaseBytes, 1'b1);

        // final stretch without idling
        start_phase(DefaultMsgId, 1'b0);
        queue_messages(PhaseBytes, 1'b1);

        wait_drained();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
src/imu_prp_pkg.sv
src/imu_prp_core.sv
src/imu_packet_record_parser.sv
tb/sv/testbench.sv
